// ===== src/xdrt_pkg.sv =====
package xdrt_pkg;

  localparam int ID_W      = 256;
  localparam int WORD_W    = 64;
  localparam int HOST_W    = 32;
  localparam int PORTS_W   = 32;
  localparam int SEEN_W    = 32;
  // Widest slot index over the whole legal range of table sizes (256 x 32).
  localparam int SLOT_W    = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int STATUS_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_W0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_W1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_W2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_W3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALE    = 3'd4;

  localparam logic [31:0] STALE_RESET = 32'd60;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NEIGHBOR  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;

  // One stored peer.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [HOST_W-1:0]  host;
    logic [PORTS_W-1:0] ports;
    logic [SEEN_W-1:0]  seen;
  } entry_t;

  // A peer travelling along the sorting chain.
  typedef struct packed {
    logic               v;
    logic [ID_W-1:0]    id;
    logic [SLOT_W-1:0]  slot;
    logic [HOST_W-1:0]  host;
    logic [PORTS_W-1:0] ports;
  } cand_t;

endpackage

// ===== src/xdrt_if.sv =====
interface xdrt_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] id_w0;
  logic [63:0] id_w1;
  logic [63:0] id_w2;
  logic [63:0] id_w3;
  logic [31:0] host_addr;
  logic [15:0] tcp_port;
  logic [15:0] udp_port;
  logic [31:0] now_seconds;
  logic [3:0]  want_count;

  modport source (output valid, kind, id_w0, id_w1, id_w2, id_w3, host_addr, tcp_port,
                  udp_port, now_seconds, want_count, input ready);
  modport sink   (input valid, kind, id_w0, id_w1, id_w2, id_w3, host_addr, tcp_port,
                  udp_port, now_seconds, want_count, output ready);
endinterface

interface xdrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        last;
  logic [63:0] peer_w0;
  logic [63:0] peer_w1;
  logic [63:0] peer_w2;
  logic [63:0] peer_w3;
  logic [31:0] peer_host;
  logic [15:0] peer_tcp;
  logic [15:0] peer_udp;

  modport source (output valid, status, last, peer_w0, peer_w1, peer_w2, peer_w3,
                  peer_host, peer_tcp, peer_udp, input ready);
  modport sink   (input valid, status, last, peer_w0, peer_w1, peer_w2, peer_w3,
                  peer_host, peer_tcp, peer_udp, output ready);
endinterface

// ===== src/xdrt_cell.sv =====
module xdrt_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clr,
  input  logic                    shift,
  input  logic [xdrt_pkg::ID_W-1:0] tgt,
  input  xdrt_pkg::cand_t         din,
  input  xdrt_pkg::cand_t         nxt_held,
  output xdrt_pkg::cand_t         pass,
  output xdrt_pkg::cand_t         held
);
  import xdrt_pkg::*;

  logic [ID_W-1:0] dist_in;
  logic [ID_W-1:0] dist_held;
  logic            lt;

  // Keys are unique: distance first, then slot index as the tie break.
  assign dist_in   = din.id ^ tgt;
  assign dist_held = held.id ^ tgt;
  assign lt        = {dist_in, din.slot} < {dist_held, held.slot};

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      held.v <= 1'b0;
      pass.v <= 1'b0;
    end else if (shift) begin
      held   <= nxt_held;
      pass.v <= 1'b0;
    end else if (din.v) begin
      if (!held.v) begin
        held   <= din;
        pass.v <= 1'b0;
      end else if (lt) begin
        held <= din;
        pass <= held;
      end else begin
        pass <= din;
      end
    end else begin
      pass.v <= 1'b0;
    end
  end

endmodule

// ===== src/xor_distance_routing_table.sv =====
// XOR-distance routing table: BUCKET_COUNT buckets of up to BUCKET_CAPACITY peers, kept
// in one single-port-read table memory. An add first counts leading zeros of ID xor local
// ID one of its four 64-bit words per cycle, then reads the bucket slot by slot through a
// read and a compare state and, on a refresh or eviction, moves the younger peers down
// one slot at a time through a read and a write state. A find streams every slot of the
// table through the memory read port at one slot per cycle into a chain of MAX_CLOSEST
// sorting cells, drains the chain, then delivers the neighbors one by one as the result
// register frees up. One item is worked on at a time; the result register lets the next
// item enter while a result waits.
// No clearing pass is needed after reset: bucket fills carry per-bucket valid bits.
module xor_distance_routing_table #(
  parameter int BUCKET_COUNT    = 256,
  parameter int BUCKET_CAPACITY = 20,
  parameter int MAX_CLOSEST     = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [xdrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xdrt_pkg::CFG_W-1:0]       cfg_wdata,
  xdrt_req_if.sink                         req,
  xdrt_rsp_if.source                       rsp
);
  import xdrt_pkg::*;

  localparam int SLOTS = BUCKET_COUNT * BUCKET_CAPACITY;
  localparam int AW    = $clog2(SLOTS);
  localparam int BW    = $clog2(BUCKET_COUNT);
  localparam int FW    = $clog2(BUCKET_CAPACITY + 1);
  localparam int SW    = (BUCKET_CAPACITY > 1) ? $clog2(BUCKET_CAPACITY) : 1;
  localparam int CW    = $clog2(MAX_CLOSEST + 1);
  localparam int TW    = $clog2(SLOTS + 1);
  localparam int DW    = $clog2(MAX_CLOSEST + 3);
  localparam int LZW   = 9;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LZC    = 11'b00000000010,
    S_BASE   = 11'b00000000100,
    S_FILL   = 11'b00000001000,
    S_SRD    = 11'b00000010000,
    S_SCMP   = 11'b00000100000,
    S_MRD    = 11'b00001000000,
    S_MWR    = 11'b00010000000,
    S_RESULT = 11'b00100000000,
    S_SCAN   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state;
  logic   draining;

  // Configuration.
  logic [ID_W-1:0] local_id;
  logic [31:0]     stale_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_id    <= '0;
      stale_limit <= STALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_W0: local_id[255:192] <= cfg_wdata;
        REG_LOCAL_W1: local_id[191:128] <= cfg_wdata;
        REG_LOCAL_W2: local_id[127:64]  <= cfg_wdata;
        REG_LOCAL_W3: local_id[63:0]    <= cfg_wdata;
        REG_STALE:    stale_limit       <= cfg_wdata[31:0];
        default:      ;
      endcase
    end
  end

  // Latched item.
  logic [ID_W-1:0]    tgt;
  logic [HOST_W-1:0]  host;
  logic [PORTS_W-1:0] ports;
  logic [SEEN_W-1:0]  now_s;
  logic [CW-1:0]      want;

  // Table memory.
  entry_t          mem [SLOTS];
  entry_t          mem_rd;
  logic [AW-1:0]   mem_raddr;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd <= mem[mem_raddr];
  end

  // Bucket fill memory with per-bucket valid bits.
  logic [FW-1:0]   fill_mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] fill_valid;
  logic [BW-1:0]   fill_raddr;
  logic [FW-1:0]   fill_rd;
  logic            fill_vrd;
  logic            fill_we;
  logic [FW-1:0]   fill_wdata;
  logic [FW-1:0]   fill_cur;
  logic [BW-1:0]   bucket;

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[bucket] <= fill_wdata;
    end
    fill_rd  <= fill_mem[fill_raddr];
    fill_vrd <= fill_valid[fill_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_valid <= '0;
    end else if (fill_we) begin
      fill_valid[bucket] <= 1'b1;
    end
  end

  assign fill_cur = fill_vrd ? fill_rd : '0;

  // Add datapath.
  logic [1:0]     wsel;
  logic [LZW-1:0] lz;
  logic [WORD_W-1:0] wx;
  logic [BW-1:0]  bkt;
  logic [AW-1:0]  base;
  logic [FW-1:0]  fill;
  logic [FW-1:0]  sidx;
  logic [FW-1:0]  kidx;
  logic [SEEN_W-1:0] seen0;
  logic [STATUS_W-1:0] res_status;
  logic [TW-1:0]  total;
  logic           stale;

  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  assign wx    = tgt[{~wsel, 6'd0} +: WORD_W] ^ local_id[{~wsel, 6'd0} +: WORD_W];
  assign bkt   = (lz >= LZW'(BUCKET_COUNT)) ? BW'(BUCKET_COUNT - 1) : lz[BW-1:0];
  assign stale = (now_s - seen0) > stale_limit;

  // Find datapath.
  logic [AW-1:0]  sc_a;
  logic [BW-1:0]  sc_b;
  logic [SW-1:0]  sc_s;
  logic           p_v;
  logic [AW-1:0]  p_a;
  logic [SW-1:0]  p_s;
  logic [DW-1:0]  dcnt;
  logic [CW-1:0]  kout;
  logic           clr;
  logic           shift;
  cand_t          cand0;
  cand_t          c_pass [MAX_CLOSEST];
  cand_t          c_held [MAX_CLOSEST];
  logic [15:0]    want_w;

  always_comb begin
    want_w = 16'(req.want_count);
    if (want_w > 16'(MAX_CLOSEST)) want_w = 16'(MAX_CLOSEST);
    if (want_w > 16'(total)) want_w = 16'(total);
  end

  always_comb begin
    cand0.v     = p_v && fill_vrd && (FW'(p_s) < fill_rd);
    cand0.id    = mem_rd.id;
    cand0.slot  = SLOT_W'(p_a);
    cand0.host  = mem_rd.host;
    cand0.ports = mem_rd.ports;
  end

  for (genvar i = 0; i < MAX_CLOSEST; i++) begin : g_cell
    xdrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (clr),
      .shift    (shift),
      .tgt      (tgt),
      .din      ((i == 0) ? cand0 : c_pass[(i == 0) ? 0 : i - 1]),
      .nxt_held ((i == MAX_CLOSEST - 1) ? '0 : c_held[(i == MAX_CLOSEST - 1) ? i : i + 1]),
      .pass     (c_pass[i]),
      .held     (c_held[i])
    );
  end

  // Result register.
  logic                out_v;
  logic [STATUS_W-1:0] out_status;
  logic                out_last;
  logic [ID_W-1:0]     out_id;
  logic [HOST_W-1:0]   out_host;
  logic [PORTS_W-1:0]  out_ports;
  logic                out_free;
  logic                out_load;

  assign out_free = !out_v || rsp.ready;
  assign out_load = out_free && ((state == S_RESULT) || (state == S_OUT));
  assign shift    = out_load && (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_load) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_OUT) begin
        out_status <= ST_NEIGHBOR;
        out_last   <= (kout == want - CW'(1));
        out_id     <= c_held[0].id;
        out_host   <= c_held[0].host;
        out_ports  <= c_held[0].ports;
      end else begin
        out_status <= res_status;
        out_last   <= 1'b1;
        out_id     <= '0;
        out_host   <= '0;
        out_ports  <= '0;
      end
    end
  end

  assign rsp.valid     = out_v;
  assign rsp.status    = out_status;
  assign rsp.last      = out_last;
  assign rsp.peer_w0   = out_id[255:192];
  assign rsp.peer_w1   = out_id[191:128];
  assign rsp.peer_w2   = out_id[127:64];
  assign rsp.peer_w3   = out_id[63:0];
  assign rsp.peer_host = out_host;
  assign rsp.peer_tcp  = out_ports[31:16];
  assign rsp.peer_udp  = out_ports[15:0];

  assign req.ready = (state == S_IDLE);

  // Memory port steering.
  always_comb begin
    mem_raddr  = sc_a;
    fill_raddr = sc_b;
    mem_we     = 1'b0;
    mem_waddr  = base + AW'(fill);
    mem_wdata  = '{id: tgt, host: host, ports: ports, seen: now_s};
    fill_we    = 1'b0;
    fill_wdata = fill + FW'(1);
    clr        = (state == S_IDLE) && req.valid && (req.kind == KIND_FIND);
    case (state)
      S_BASE: fill_raddr = bkt;
      S_SRD: begin
        mem_raddr = base + AW'(sidx);
        if (sidx == fill && fill < FW'(BUCKET_CAPACITY)) begin
          mem_we  = 1'b1;
          fill_we = 1'b1;
        end
      end
      S_MRD: begin
        mem_raddr = base + AW'(kidx);
        if (kidx == fill) begin
          mem_we    = 1'b1;
          mem_waddr = base + AW'(fill) - AW'(1);
        end
      end
      S_MWR: begin
        mem_we    = 1'b1;
        mem_waddr = base + AW'(kidx) - AW'(1);
        mem_wdata = mem_rd;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      total    <= '0;
      p_v      <= 1'b0;
      draining <= 1'b0;
    end else begin
      p_v <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            tgt   <= {req.id_w0, req.id_w1, req.id_w2, req.id_w3};
            host  <= req.host_addr;
            ports <= {req.tcp_port, req.udp_port};
            now_s <= req.now_seconds;
            wsel  <= 2'd0;
            lz    <= '0;
            want  <= CW'(want_w);
            sc_a  <= '0;
            sc_b  <= '0;
            sc_s  <= '0;
            draining <= 1'b0;
            if (req.kind == KIND_ADD) begin
              if (req.tcp_port == 16'd0 || req.udp_port == 16'd0) begin
                res_status <= ST_REJECTED;
                state      <= S_RESULT;
              end else begin
                state <= S_LZC;
              end
            end else if (want_w == 16'd0) begin
              res_status <= ST_NONE;
              state      <= S_RESULT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_LZC: begin
          if (wx != '0) begin
            lz    <= lz + LZW'(lzc64(wx));
            state <= S_BASE;
          end else if (wsel == 2'd3) begin
            // The peer is this node itself.
            res_status <= ST_REJECTED;
            state      <= S_RESULT;
          end else begin
            lz   <= lz + LZW'(64);
            wsel <= wsel + 2'd1;
          end
        end
        S_BASE: begin
          bucket <= bkt;
          base   <= AW'(bkt * BUCKET_CAPACITY);
          state  <= S_FILL;
        end
        S_FILL: begin
          fill  <= fill_cur;
          sidx  <= '0;
          state <= S_SRD;
        end
        S_SRD: begin
          if (sidx == fill) begin
            if (fill < FW'(BUCKET_CAPACITY)) begin
              total      <= total + TW'(1);
              res_status <= ST_INSERTED;
              state      <= S_RESULT;
            end else if (stale) begin
              // Evict the oldest peer by moving the whole bucket down one slot.
              kidx       <= FW'(1);
              res_status <= ST_INSERTED;
              state      <= S_MRD;
            end else begin
              res_status <= ST_DROPPED;
              state      <= S_RESULT;
            end
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (sidx == '0) seen0 <= mem_rd.seen;
          if (mem_rd.id == tgt) begin
            kidx       <= sidx + FW'(1);
            res_status <= ST_REFRESHED;
            state      <= S_MRD;
          end else begin
            sidx  <= sidx + FW'(1);
            state <= S_SRD;
          end
        end
        S_MRD: begin
          if (kidx == fill) state <= S_RESULT;
          else state <= S_MWR;
        end
        S_MWR: begin
          kidx  <= kidx + FW'(1);
          state <= S_MRD;
        end
        S_RESULT: begin
          if (out_free) state <= S_IDLE;
        end
        S_SCAN: begin
          if (!draining) begin
            p_v <= 1'b1;
            p_a <= sc_a;
            p_s <= sc_s;
            sc_a <= sc_a + AW'(1);
            if (sc_s == SW'(BUCKET_CAPACITY - 1)) begin
              sc_s <= '0;
              sc_b <= sc_b + BW'(1);
            end else begin
              sc_s <= sc_s + SW'(1);
            end
            if (sc_a == AW'(SLOTS - 1)) begin
              draining <= 1'b1;
              dcnt     <= '0;
            end
          end else if (dcnt == DW'(MAX_CLOSEST + 1)) begin
            kout  <= '0;
            state <= S_OUT;
          end else begin
            dcnt <= dcnt + DW'(1);
          end
        end
        S_OUT: begin
          if (out_load) begin
            if (kout == want - CW'(1)) state <= S_IDLE;
            else kout <= kout + CW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TW'(SLOTS))
    else $error("peer count exceeds table size");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_we |-> (fill_wdata <= FW'(BUCKET_CAPACITY)))
    else $error("bucket fill written beyond capacity");

  a_no_write_in_find: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_OUT) |-> !mem_we)
    else $error("table written during a find");

  a_neighbor_held: assert property (@(posedge clk) disable iff (rst)
    shift |-> c_held[0].v)
    else $error("neighbor delivered from an empty sorting cell");

endmodule

// ===== verif/tb_xor_distance_routing_table.sv =====
module tb_xor_distance_routing_table;
  import xdrt_pkg::*;

  localparam int NBUCKETS    = 256;
  localparam int BUCKET_SIZE = 20;
  localparam int NEAREST_MAX = 8;
  localparam int NSLOTS      = NBUCKETS * BUCKET_SIZE;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [255:0] id;
    logic [31:0] host;
    logic [15:0] tcp;
    logic [15:0] udp;
    logic [31:0] now;
    logic [3:0]  want;
  } peer_req_t;

  typedef struct packed {
    logic [2:0]   status;
    logic         last;
    logic [255:0] id;
    logic [31:0]  host;
    logic [15:0]  tcp;
    logic [15:0]  udp;
  } peer_rsp_t;

  class routing_scoreboard;
    logic [255:0] local_id;
    logic [31:0]  stale_limit;
    logic [255:0] ids[NSLOTS];
    logic [31:0]  hosts[NSLOTS];
    logic [31:0]  ports[NSLOTS];
    logic [31:0]  seen[NSLOTS];
    int           fill[NBUCKETS];
    peer_rsp_t    pending[$];
    int           errors;

    function new();
      local_id = '0;
      stale_limit = STALE_RESET;
      foreach (fill[i]) fill[i] = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        REG_LOCAL_W0: local_id[255:192] = data;
        REG_LOCAL_W1: local_id[191:128] = data;
        REG_LOCAL_W2: local_id[127:64]  = data;
        REG_LOCAL_W3: local_id[63:0]    = data;
        REG_STALE:    stale_limit       = data[31:0];
        default: ;
      endcase
    endfunction

    function int bucket_for(logic [255:0] id);
      logic [255:0] x;
      x = id ^ local_id;
      for (int i = 255; i >= 0; i--)
        if (x[i]) return 255 - i;
      return NBUCKETS - 1;
    endfunction

    function void put_slot(int slot, peer_req_t r);
      ids[slot] = r.id;
      hosts[slot] = r.host;
      ports[slot] = {r.tcp, r.udp};
      seen[slot] = r.now;
    endfunction

    // Slides the younger peers of a bucket down over slot base+from.
    function void slide_down(int base, int from, int n);
      for (int s = from; s + 1 < n; s++) begin
        ids[base+s] = ids[base+s+1];
        hosts[base+s] = hosts[base+s+1];
        ports[base+s] = ports[base+s+1];
        seen[base+s] = seen[base+s+1];
      end
    endfunction

    function logic [2:0] add_peer(peer_req_t r);
      int b;
      int base;
      int n;
      logic [31:0] age;
      if (r.id == local_id || r.tcp == 0 || r.udp == 0) return ST_REJECTED;
      b = bucket_for(r.id);
      base = b * BUCKET_SIZE;
      n = fill[b];
      for (int s = 0; s < n; s++) begin
        if (ids[base+s] == r.id) begin
          slide_down(base, s, n);
          put_slot(base + n - 1, r);
          return ST_REFRESHED;
        end
      end
      if (n < BUCKET_SIZE) begin
        put_slot(base + n, r);
        fill[b] = n + 1;
        return ST_INSERTED;
      end
      age = r.now - seen[base];
      if (age > stale_limit) begin
        slide_down(base, 0, n);
        put_slot(base + n - 1, r);
        return ST_INSERTED;
      end
      return ST_DROPPED;
    endfunction

    function bit closer(logic [255:0] tgt, int a, int b);
      logic [255:0] da;
      logic [255:0] db;
      da = ids[a] ^ tgt;
      db = ids[b] ^ tgt;
      if (da != db) return da < db;
      return a < b;
    endfunction

    function void note(peer_req_t r);
      peer_rsp_t e;
      int total;
      int want;
      int prev;
      int best;
      e = '0;
      e.last = 1'b1;
      if (r.kind == KIND_ADD) begin
        e.status = add_peer(r);
        pending.insert(pending.size(), e);
        return;
      end
      total = 0;
      foreach (fill[b]) total += fill[b];
      want = r.want;
      if (want > NEAREST_MAX) want = NEAREST_MAX;
      if (want > total) want = total;
      if (want == 0) begin
        e.status = ST_NONE;
        pending.insert(pending.size(), e);
        return;
      end
      prev = -1;
      for (int k = 0; k < want; k++) begin
        best = -1;
        for (int b = 0; b < NBUCKETS; b++)
          for (int s = 0; s < fill[b]; s++) begin
            int slot;
            slot = b * BUCKET_SIZE + s;
            if (prev >= 0 && !closer(r.id, prev, slot)) continue;
            if (best < 0 || closer(r.id, slot, best)) best = slot;
          end
        e.status = ST_NEIGHBOR;
        e.last = (k + 1 == want);
        e.id = ids[best];
        e.host = hosts[best];
        e.tcp = ports[best][31:16];
        e.udp = ports[best][15:0];
        pending.insert(pending.size(), e);
        prev = best;
      end
    endfunction

    function void check(peer_rsp_t got);
      peer_rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.last !== e.last || got.id !== e.id ||
          got.host !== e.host || got.tcp !== e.tcp || got.udp !== e.udp) begin
        $display("%0t: mismatch expected %p actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int send_idle;
  int recv_idle;
  int cycles;
  logic [31:0] clock_now;
  peer_req_t known[$];

  routing_scoreboard table_sb = new();

  xdrt_req_if req_ch();
  xdrt_rsp_if rsp_ch();

  xor_distance_routing_table dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .req(req_ch), .rsp(rsp_ch)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: sample the beat of this edge, then pick the next ready.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      table_sb.check({rsp_ch.status, rsp_ch.last, rsp_ch.peer_w0, rsp_ch.peer_w1,
                      rsp_ch.peer_w2, rsp_ch.peer_w3, rsp_ch.peer_host,
                      rsp_ch.peer_tcp, rsp_ch.peer_udp});
    rsp_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [255:0] rand_word256();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic peer_req_t add_item(logic [255:0] id, logic [31:0] host,
                                         logic [15:0] tcp, logic [15:0] udp,
                                         logic [31:0] now);
    peer_req_t r;
    r = '0;
    r.kind = KIND_ADD;
    r.id = id;
    r.host = host;
    r.tcp = tcp;
    r.udp = udp;
    r.now = now;
    r.want = 4'($urandom);
    return r;
  endfunction

  function automatic peer_req_t find_item(logic [255:0] id, logic [3:0] want);
    peer_req_t r;
    r = add_item(id, $urandom, 16'($urandom), 16'($urandom), $urandom);
    r.kind = KIND_FIND;
    r.want = want;
    return r;
  endfunction

  task automatic send(peer_req_t r);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= r.kind;
    {req_ch.id_w0, req_ch.id_w1, req_ch.id_w2, req_ch.id_w3} <= r.id;
    req_ch.host_addr <= r.host;
    req_ch.tcp_port <= r.tcp;
    req_ch.udp_port <= r.udp;
    req_ch.now_seconds <= r.now;
    req_ch.want_count <= r.want;
    do @(posedge clk); while (!req_ch.ready);
    table_sb.note(r);
    if (r.kind == KIND_ADD && r.tcp != 0 && r.udp != 0) known.insert(known.size(), r);
  endtask

  // Waits until the table is idle, then writes one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (table_sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_sb.write_reg(idx, data);
  endtask

  task automatic set_local(logic [255:0] id);
    write_reg(REG_LOCAL_W0, id[255:192]);
    write_reg(REG_LOCAL_W1, id[191:128]);
    write_reg(REG_LOCAL_W2, id[127:64]);
    write_reg(REG_LOCAL_W3, id[63:0]);
  endtask

  task automatic random_items(int count);
    peer_req_t r;
    logic [255:0] id;
    int pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) clock_now = clock_now + $urandom;
      else clock_now = clock_now + $urandom_range(0, 30);
      pick = $urandom_range(99);
      if (pick < 20) begin
        if (known.size() != 0 && $urandom_range(1))
          id = known[$urandom_range(known.size() - 1)].id;
        else
          id = rand_word256();
        send(find_item(id, 4'($urandom)));
      end else if (pick < 40 && known.size() != 0) begin
        r = known[$urandom_range(known.size() - 1)];
        send(add_item(r.id, $urandom, 16'($urandom_range(1, 65535)),
                      16'($urandom_range(1, 65535)), clock_now));
      end else if (pick < 45) begin
        send(add_item(table_sb.local_id, $urandom, 16'($urandom_range(1, 65535)),
                      16'($urandom_range(1, 65535)), clock_now));
      end else if (pick < 50) begin
        send(add_item(rand_word256(), $urandom, $urandom_range(1) ? 16'd0 : 16'($urandom),
                      $urandom_range(1) ? 16'd0 : 16'($urandom), clock_now));
      end else begin
        // Shifted masks spread peers over the deep buckets as well as the shallow ones.
        id = table_sb.local_id ^ (rand_word256() >> $urandom_range(0, 255));
        send(add_item(id, $urandom, 16'($urandom_range(1, 65535)),
                      16'($urandom_range(1, 65535)), clock_now));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_ADD;
    {req_ch.id_w0, req_ch.id_w1, req_ch.id_w2, req_ch.id_w3} <= '0;
    req_ch.host_addr <= '0;
    req_ch.tcp_port <= '0;
    req_ch.udp_port <= '0;
    req_ch.now_seconds <= '0;
    req_ch.want_count <= '0;
    cycles <= 0;
    send_idle = 0;
    recv_idle = 0;
    clock_now = 32'd100;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with reset configuration: local ID zero, stale limit 60.
    send(find_item('0, 4'd5));
    send(add_item('0, 32'h0a000001, 16'd80, 16'd81, 32'd10));
    send(add_item({255'd0, 1'b1}, 32'h0a000002, 16'd0, 16'd81, 32'd10));
    send(add_item({255'd0, 1'b1}, 32'h0a000002, 16'd80, 16'd0, 32'd10));
    send(add_item({255'd0, 1'b1}, 32'h0, 16'd1, 16'd1, 32'd0));
    send(add_item('1, 32'hffffffff, 16'hffff, 16'hffff, 32'hffffffff));
    send(add_item({1'b1, 255'd0}, 32'h01020304, 16'd1, 16'hffff, 32'd5));
    send(add_item({255'd0, 1'b1}, 32'h05060708, 16'hffff, 16'd1, 32'd20));
    send(add_item({254'd0, 2'b11}, 32'h0a0b0c0d, 16'd9, 16'd9, 32'd20));
    send(find_item('0, 4'd0));
    send(find_item('0, 4'd8));
    send(find_item('1, 4'd15));
    send(find_item({1'b1, 255'd0}, 4'd2));
    send(find_item({254'd0, 2'b10}, 4'd1));
    for (int i = 0; i < 8; i++)
      send(add_item({1'b1, 191'd0, 64'($urandom)}, $urandom, 16'd7, 16'd7, 32'd30));

    set_local(rand_word256());
    write_reg(REG_STALE, 64'd0);
    write_reg(REG_UNUSED, '1);
    send_idle = 37;
    recv_idle = 82;
    random_items(30);

    set_local('1);
    write_reg(REG_STALE, 64'hffffffff);
    send_idle = 82;
    recv_idle = 37;
    random_items(30);

    write_reg(REG_LOCAL_W0, {$urandom, $urandom});
    write_reg(REG_STALE, 64'($urandom_range(0, 200)));
    send_idle = 0;
    recv_idle = 0;
    random_items(30);

    req_ch.valid <= 1'b0;
    while (table_sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (table_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/xdrt_pkg.sv
src/xdrt_if.sv
src/xdrt_cell.sv
src/xor_distance_routing_table.sv
verif/tb_xor_distance_routing_table.sv
